FILE: sv/rvx_pkg.sv
// Shared types, encodings and helpers for the RV64I execute unit.
// No dependencies; imported by the top, rvx_exec, the checker and the testbench.
`default_nettype none
package rvx_pkg;

  localparam int unsigned XLEN     = 64;
  localparam int unsigned NREGS    = 32;
  localparam int unsigned RIDX_W   = 5;
  localparam int unsigned ILEN     = 32;
  localparam int unsigned S_DATA_W = 96;
  localparam int unsigned M_DATA_W = 272;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM32  = 7'h1B;
  localparam logic [6:0] OP_REG32  = 7'h3B;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_FENCE  = 7'h0F;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [5:0] F6_BASE = 6'h00;
  localparam logic [5:0] F6_ALT  = 6'h10;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] F3_LBAD = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNSUP   = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] SIZE_D = 2'd3;

  typedef struct packed {
    logic              pending;
    logic [RIDX_W-1:0] dest;
    logic [1:0]        size;
    logic              zext;
  } ld_state_t;

  typedef struct packed {
    logic              wb;
    logic [RIDX_W-1:0] rd;
    logic [XLEN-1:0]   val;
    logic [XLEN-1:0]   npc;
    logic [1:0]        mreq;
    logic [XLEN-1:0]   maddr;
    logic [1:0]        msize;
    logic [XLEN-1:0]   sdata;
    logic [1:0]        st;
  } res_t;

  function automatic logic [XLEN-1:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage
`default_nettype wire

FILE: sv/rv64i_integer_execute_unit_top.sv
// RV64I execute unit top: input stage, register file RAM, pc and load state, result register.
// Depends on rvx_pkg, rvx_ram and rvx_exec.
`default_nettype none
// Takes one transaction per cycle while the output is not stalled and returns one result per
// transaction: the accepting edge reads the register file RAM into the input stage, then the
// item executes and the edge that fires it out writes the result register, the register file
// and the pc. While a result waits with m_axis_tready low, a full input stage holds and
// s_axis_tready drops.
// A write from the executing item is forwarded to the item being read in the same cycle.
// The pc comes out of reset at zero; start_address is a register written through the
// configuration channel and is copied into the pc in the first cycle after reset.
module rv64i_integer_execute_unit_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rvx_pkg::XLEN-1:0]       cfg_data_i,      // start_address
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [rvx_pkg::S_DATA_W-1:0]   s_axis_tdata,    // instruction, load_data
  input  wire logic                           s_axis_tuser,    // mode
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [rvx_pkg::M_DATA_W-1:0]        m_axis_tdata     // reg_write, reg_index,
                                                               // reg_value, next_pc,
                                                               // mem_request, mem_address,
                                                               // mem_size, store_data,
                                                               // status, pad
);
  import rvx_pkg::*;

  logic             s1_valid_q, out_valid_q, init_q;
  logic             mode_q;
  logic [ILEN-1:0]  instr_q;
  logic [XLEN-1:0]  ldata_q, fwd_val_q, start_q, pc_q;
  logic             fwd_a_q, fwd_b_q, vld_a_q, vld_b_q;
  logic [NREGS-1:0] rvalid_q;
  ld_state_t        ld_q, ld_d;
  res_t             res_d, out_q;
  logic             in_fire, ex_fire, rf_we;
  logic [RIDX_W-1:0] rs1, rs2;
  logic [XLEN-1:0]  rd_a, rd_b, op_a, op_b;

  assign cfg_ready_o   = 1'b1;
  assign ex_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || ex_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign rf_we         = ex_fire && res_d.wb;
  assign rs1           = s_axis_tdata[19:15];
  assign rs2           = s_axis_tdata[24:20];
  assign op_a          = fwd_a_q ? fwd_val_q : (vld_a_q ? rd_a : '0);
  assign op_b          = fwd_b_q ? fwd_val_q : (vld_b_q ? rd_b : '0);

  rvx_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (res_d.rd),
    .wdata_i   (res_d.val),
    .re_i      (in_fire),
    .raddr_a_i (rs1),
    .raddr_b_i (rs2),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  rvx_exec u_exec (
    .mode_i      (mode_q),
    .instr_i     (instr_q),
    .load_data_i (ldata_q),
    .a_i         (op_a),
    .b_i         (op_b),
    .pc_i        (pc_q),
    .ld_i        (ld_q),
    .ld_o        (ld_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      init_q      <= 1'b1;
      start_q     <= '0;
      pc_q        <= '0;
      ld_q        <= '0;
      rvalid_q    <= '0;
    end else begin
      init_q <= 1'b0;
      if (cfg_valid_i) begin
        start_q <= cfg_data_i;
      end
      if (init_q) begin
        pc_q <= start_q;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (ex_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (ex_fire) begin
        out_valid_q <= 1'b1;
        pc_q        <= res_d.npc;
        ld_q        <= ld_d;
        if (rf_we) begin
          rvalid_q[res_d.rd] <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= s_axis_tuser;
      instr_q   <= s_axis_tdata[ILEN-1:0];
      ldata_q   <= s_axis_tdata[ILEN +: XLEN];
      vld_a_q   <= rvalid_q[rs1];
      vld_b_q   <= rvalid_q[rs2];
      fwd_a_q   <= rf_we && (res_d.rd == rs1);
      fwd_b_q   <= rf_we && (res_d.rd == rs2);
      fwd_val_q <= res_d.val;
    end
    if (ex_fire) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.st, out_q.sdata, out_q.msize, out_q.maddr, out_q.mreq,
                          out_q.npc, out_q.val, out_q.rd, out_q.wb};

endmodule
`default_nettype wire

FILE: sv/rvx_ram.sv
// Generic RAM: one write port, two registered read ports with a shared enable.
// No dependencies.
`default_nettype none
module rvx_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

FILE: sv/rvx_exec.sv
// Combinational decode and execute of one item: ALU, branches, memory ops, load return.
// Depends on rvx_pkg.
`default_nettype none
module rvx_exec (
  input  wire logic                     mode_i,
  input  wire logic [rvx_pkg::ILEN-1:0] instr_i,
  input  wire logic [rvx_pkg::XLEN-1:0] load_data_i,
  input  wire logic [rvx_pkg::XLEN-1:0] a_i,
  input  wire logic [rvx_pkg::XLEN-1:0] b_i,
  input  wire logic [rvx_pkg::XLEN-1:0] pc_i,
  input  wire rvx_pkg::ld_state_t       ld_i,
  output rvx_pkg::ld_state_t            ld_o,
  output rvx_pkg::res_t                 res_o
);
  import rvx_pkg::*;

  logic [6:0]      op, f7;
  logic [2:0]      f3;
  logic [5:0]      top6;
  logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_u, imm_j, pc4, alu_b, sh_a, d;
  logic [5:0]      sham;
  logic [4:0]      wsh;
  logic [31:0]     w_b, w_r;
  logic            alt, taken, slt, sltu;
  res_t            r;
  ld_state_t       l;

  always_comb begin
    op    = instr_i[6:0];
    f3    = instr_i[14:12];
    f7    = instr_i[31:25];
    top6  = instr_i[31:26];
    imm_i = {{52{instr_i[31]}}, instr_i[31:20]};
    imm_s = {{52{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
    imm_b = {{51{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
    imm_u = {{32{instr_i[31]}}, instr_i[31:12], 12'b0};
    imm_j = {{43{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20], instr_i[30:21],
             1'b0};
    pc4   = pc_i + XLEN'(4);

    alt   = 1'b0;
    alu_b = b_i;
    w_b   = b_i[31:0];
    case (op)
      OP_IMM: begin
        alt   = (f3 == F3_SR) && (top6 == F6_ALT);
        alu_b = ((f3 == F3_SLL) || (f3 == F3_SR)) ? {58'b0, instr_i[25:20]} : imm_i;
      end
      OP_IMM32: begin
        alt = (f3 != F3_ADD) && (f7 == F7_ALT);
        w_b = (f3 == F3_ADD) ? imm_i[31:0] : {27'b0, instr_i[24:20]};
      end
      OP_REG, OP_REG32: alt = (f7 == F7_ALT);
      default: ;
    endcase

    slt  = $signed(a_i) < $signed(alu_b);
    sltu = a_i < alu_b;
    sham = alu_b[5:0];
    case (f3)
      F3_ADD:  sh_a = alt ? a_i - alu_b : a_i + alu_b;
      F3_SLL:  sh_a = a_i << sham;
      F3_SLT:  sh_a = {63'b0, slt};
      F3_SLTU: sh_a = {63'b0, sltu};
      F3_XOR:  sh_a = a_i ^ alu_b;
      F3_SR:   sh_a = alt ? XLEN'($signed(a_i) >>> sham) : a_i >> sham;
      F3_OR:   sh_a = a_i | alu_b;
      default: sh_a = a_i & alu_b;
    endcase

    wsh = w_b[4:0];
    if (f3 == F3_ADD) begin
      w_r = alt ? a_i[31:0] - w_b : a_i[31:0] + w_b;
    end else if (f3 == F3_SLL) begin
      w_r = a_i[31:0] << wsh;
    end else if (alt) begin
      w_r = 32'($signed(a_i[31:0]) >>> wsh);
    end else begin
      w_r = a_i[31:0] >> wsh;
    end

    case (f3)
      F3_BEQ:  taken = a_i == b_i;
      F3_BNE:  taken = a_i != b_i;
      F3_BLT:  taken = $signed(a_i) < $signed(b_i);
      F3_BGE:  taken = !($signed(a_i) < $signed(b_i));
      F3_BLTU: taken = a_i < b_i;
      F3_BGEU: taken = a_i >= b_i;
      default: taken = 1'b0;
    endcase

    case (ld_i.size)
      2'd0:    d = ld_i.zext ? {56'b0, load_data_i[7:0]}  : {{56{load_data_i[7]}},  load_data_i[7:0]};
      2'd1:    d = ld_i.zext ? {48'b0, load_data_i[15:0]} : {{48{load_data_i[15]}}, load_data_i[15:0]};
      2'd2:    d = ld_i.zext ? {32'b0, load_data_i[31:0]} : sext32(load_data_i[31:0]);
      default: d = load_data_i;
    endcase

    r       = '0;
    r.npc   = pc_i;
    l       = ld_i;
    if (mode_i) begin
      if (!ld_i.pending) begin
        r.st = ST_ILLEGAL;
      end else begin
        r.wb      = 1'b1;
        r.rd      = ld_i.dest;
        r.val     = d;
        l.pending = 1'b0;
      end
    end else begin
      l.pending = 1'b0;
      r.rd      = instr_i[11:7];
      r.npc     = pc4;
      case (op)
        OP_LUI: begin
          r.val = imm_u;
          r.wb  = 1'b1;
        end
        OP_AUIPC: begin
          r.val = pc_i + imm_u;
          r.wb  = 1'b1;
        end
        OP_JAL: begin
          r.val = pc4;
          r.wb  = 1'b1;
          r.npc = pc_i + imm_j;
        end
        OP_JALR: begin
          if (f3 != F3_ADD) begin
            r.st = ST_ILLEGAL;
          end else begin
            r.val = pc4;
            r.wb  = 1'b1;
            r.npc = (a_i + imm_i) & ~XLEN'(1);
          end
        end
        OP_BRANCH: begin
          if (f3 == 3'd2 || f3 == 3'd3) begin
            r.st = ST_ILLEGAL;
          end else if (taken) begin
            r.npc = pc_i + imm_b;
          end
        end
        OP_LOAD: begin
          if (f3 == F3_LBAD) begin
            r.st = ST_ILLEGAL;
          end else begin
            r.mreq    = MEM_LOAD;
            r.maddr   = a_i + imm_i;
            r.msize   = f3[1:0];
            l.pending = 1'b1;
            l.dest    = instr_i[11:7];
            l.size    = f3[1:0];
            l.zext    = f3[2];
          end
        end
        OP_STORE: begin
          if (f3[2]) begin
            r.st = ST_ILLEGAL;
          end else begin
            r.mreq  = MEM_STORE;
            r.maddr = a_i + imm_s;
            r.msize = f3[1:0];
            r.sdata = b_i;
          end
        end
        OP_IMM: begin
          if ((f3 == F3_SLL && top6 != F6_BASE)
              || (f3 == F3_SR && top6 != F6_BASE && top6 != F6_ALT)) begin
            r.st = ST_ILLEGAL;
          end else begin
            r.val = sh_a;
            r.wb  = 1'b1;
          end
        end
        OP_REG: begin
          if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
            r.val = sh_a;
            r.wb  = 1'b1;
          end else begin
            r.st = ST_ILLEGAL;
          end
        end
        OP_IMM32: begin
          if (f3 == F3_ADD || (f3 == F3_SLL && f7 == F7_BASE)
              || (f3 == F3_SR && (f7 == F7_BASE || f7 == F7_ALT))) begin
            r.val = sext32(w_r);
            r.wb  = 1'b1;
          end else begin
            r.st = ST_ILLEGAL;
          end
        end
        OP_REG32: begin
          if (((f3 == F3_ADD || f3 == F3_SR) && (f7 == F7_BASE || f7 == F7_ALT))
              || (f3 == F3_SLL && f7 == F7_BASE)) begin
            r.val = sext32(w_r);
            r.wb  = 1'b1;
          end else begin
            r.st = ST_ILLEGAL;
          end
        end
        OP_SYSTEM, OP_FENCE: r.st = ST_UNSUP;
        default: r.st = ST_ILLEGAL;
      endcase
      if (r.st != ST_OK) begin
        r.wb      = 1'b0;
        r.npc     = pc_i;
        r.mreq    = MEM_NONE;
        r.maddr   = '0;
        r.msize   = '0;
        r.sdata   = '0;
        l.pending = 1'b0;
      end
    end
    if (!r.wb || r.rd == '0) begin
      r.wb  = 1'b0;
      r.rd  = '0;
      r.val = '0;
    end
    res_o = r;
    ld_o  = l;
  end

endmodule
`default_nettype wire

FILE: sv/rvx_checker.sv
// Port-level checker for the RV64I execute unit, bound to the top level.
// Depends on rvx_pkg.
`default_nettype none
module rvx_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [rvx_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import rvx_pkg::*;

  logic            wb;
  logic [1:0]      st, mreq;

  assign wb   = m_axis_tdata[0];
  assign mreq = m_axis_tdata[135:134];
  assign st   = m_axis_tdata[267:266];

  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st != ST_OK |-> !wb && mreq == MEM_NONE)
    else $error("faulting result writes or requests");

  a_no_wb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !wb |-> m_axis_tdata[69:1] == '0)
    else $error("no write but index or value nonzero");

  a_no_mem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mreq == MEM_NONE |->
      m_axis_tdata[199:136] == '0 && m_axis_tdata[265:200] == '0)
    else $error("no request but address, size or data nonzero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind rv64i_integer_execute_unit_top rvx_checker u_rvx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the RV64I execute unit: directed and random instruction streams.
// Depends on rvx_pkg and rv64i_integer_execute_unit_top; predicts every result internally.
`default_nettype none
module testbench;
  import rvx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [XLEN-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  rv64i_integer_execute_unit_top i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [XLEN-1:0] gpr [NREGS];
  logic [XLEN-1:0] pc_model;
  ld_state_t       ld_model;
  res_t            expected_q [$];
  int unsigned     mismatches = 0;
  bit              no_gaps = 1'b0;

  function automatic logic [XLEN-1:0] alu_result(logic [2:0] f3, bit alt,
                                                 logic [XLEN-1:0] a, logic [XLEN-1:0] b);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[5:0];
      F3_SLT:  return {63'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {63'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? $unsigned($signed(a) >>> b[5:0]) : a >> b[5:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [XLEN-1:0] word_result(logic [2:0] f3, bit alt,
                                                  logic [XLEN-1:0] a, logic [XLEN-1:0] b);
    logic [31:0] x, r;
    x = a[31:0];
    if (f3 == F3_ADD) r = alt ? x - b[31:0] : x + b[31:0];
    else if (f3 == F3_SLL) r = x << b[4:0];
    else if (alt) r = $unsigned($signed(x) >>> b[4:0]);
    else r = x >> b[4:0];
    return {{32{r[31]}}, r};
  endfunction

  function automatic res_t execute_item(bit mode, logic [31:0] ins, logic [63:0] ld);
    res_t r;
    logic [6:0] op, f7;
    logic [2:0] f3;
    logic [5:0] f6;
    logic [XLEN-1:0] a, b, imm_i, imm_s, imm_b, imm_u, imm_j, d;
    bit taken;
    r = '0;
    r.npc = pc_model;
    if (mode) begin
      if (!ld_model.pending) r.st = ST_ILLEGAL;
      else begin
        d = ld;
        case (ld_model.size)
          2'd0: d = ld_model.zext ? {56'd0, ld[7:0]} : {{56{ld[7]}}, ld[7:0]};
          2'd1: d = ld_model.zext ? {48'd0, ld[15:0]} : {{48{ld[15]}}, ld[15:0]};
          2'd2: d = ld_model.zext ? {32'd0, ld[31:0]} : {{32{ld[31]}}, ld[31:0]};
          default: d = ld;
        endcase
        r.rd = ld_model.dest;
        r.val = d;
        r.wb = 1'b1;
        ld_model.pending = 1'b0;
      end
    end else begin
      op = ins[6:0];
      f3 = ins[14:12];
      f7 = ins[31:25];
      f6 = ins[31:26];
      a = gpr[ins[19:15]];
      b = gpr[ins[24:20]];
      imm_i = {{52{ins[31]}}, ins[31:20]};
      imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
      imm_b = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      imm_u = {{32{ins[31]}}, ins[31:12], 12'd0};
      imm_j = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      ld_model.pending = 1'b0;
      r.rd = ins[11:7];
      r.npc = pc_model + 64'd4;
      case (op)
        OP_LUI: begin r.val = imm_u; r.wb = 1'b1; end
        OP_AUIPC: begin r.val = pc_model + imm_u; r.wb = 1'b1; end
        OP_JAL: begin r.val = pc_model + 64'd4; r.wb = 1'b1; r.npc = pc_model + imm_j; end
        OP_JALR: begin
          if (f3 != F3_ADD) r.st = ST_ILLEGAL;
          else begin
            r.val = pc_model + 64'd4; r.wb = 1'b1;
            r.npc = (a + imm_i) & ~64'd1;
          end
        end
        OP_BRANCH: begin
          taken = 1'b0;
          case (f3)
            F3_BEQ:  taken = a == b;
            F3_BNE:  taken = a != b;
            F3_BLT:  taken = $signed(a) < $signed(b);
            F3_BGE:  taken = $signed(a) >= $signed(b);
            F3_BLTU: taken = a < b;
            F3_BGEU: taken = a >= b;
            default: r.st = ST_ILLEGAL;
          endcase
          if (taken) r.npc = pc_model + imm_b;
        end
        OP_LOAD: begin
          if (f3 == F3_LBAD) r.st = ST_ILLEGAL;
          else begin
            r.mreq = MEM_LOAD; r.maddr = a + imm_i; r.msize = f3[1:0];
            ld_model = '{pending: 1'b1, dest: ins[11:7], size: f3[1:0], zext: f3[2]};
          end
        end
        OP_STORE: begin
          if (f3[2]) r.st = ST_ILLEGAL;
          else begin
            r.mreq = MEM_STORE; r.maddr = a + imm_s; r.msize = f3[1:0]; r.sdata = b;
          end
        end
        OP_IMM: begin
          if (f3 == F3_SLL) begin
            if (f6 != F6_BASE) r.st = ST_ILLEGAL;
            else r.val = a << ins[25:20];
          end else if (f3 == F3_SR) begin
            if (f6 != F6_BASE && f6 != F6_ALT) r.st = ST_ILLEGAL;
            else r.val = alu_result(F3_SR, f6 == F6_ALT, a, {58'd0, ins[25:20]});
          end else r.val = alu_result(f3, 1'b0, a, imm_i);
          r.wb = 1'b1;
        end
        OP_REG: begin
          if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
            r.val = alu_result(f3, f7 == F7_ALT, a, b); r.wb = 1'b1;
          end else r.st = ST_ILLEGAL;
        end
        OP_IMM32: begin
          if (f3 == F3_ADD) begin
            r.val = word_result(F3_ADD, 1'b0, a, imm_i); r.wb = 1'b1;
          end else if ((f3 == F3_SLL && f7 == F7_BASE) ||
                       (f3 == F3_SR && (f7 == F7_BASE || f7 == F7_ALT))) begin
            r.val = word_result(f3, f7 == F7_ALT, a, {59'd0, ins[24:20]}); r.wb = 1'b1;
          end else r.st = ST_ILLEGAL;
        end
        OP_REG32: begin
          if (((f3 == F3_ADD || f3 == F3_SR) && (f7 == F7_BASE || f7 == F7_ALT)) ||
              (f3 == F3_SLL && f7 == F7_BASE)) begin
            r.val = word_result(f3, f7 == F7_ALT, a, b); r.wb = 1'b1;
          end else r.st = ST_ILLEGAL;
        end
        OP_SYSTEM, OP_FENCE: r.st = ST_UNSUP;
        default: r.st = ST_ILLEGAL;
      endcase
      if (r.st != ST_OK) begin
        r.wb = 1'b0; r.npc = pc_model; r.mreq = MEM_NONE;
        r.maddr = '0; r.msize = '0; r.sdata = '0;
        ld_model.pending = 1'b0;
      end
    end
    if (!r.wb || r.rd == '0) begin
      r.wb = 1'b0; r.rd = '0; r.val = '0;
    end else gpr[r.rd] = r.val;
    pc_model = r.npc;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, int rs2, int rs1, logic [2:0] f3,
                                        int rd, logic [6:0] op);
    return {f7, rs2[4:0], rs1[4:0], f3, rd[4:0], op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, int rs1, logic [2:0] f3,
                                        int rd, logic [6:0] op);
    return {imm, rs1[4:0], f3, rd[4:0], op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, int rs2, int rs1, logic [2:0] f3);
    return {imm[11:5], rs2[4:0], rs1[4:0], f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, int rs2, int rs1, logic [2:0] f3);
    return {imm[12], imm[10:5], rs2[4:0], rs1[4:0], f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, int rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd[4:0], OP_JAL};
  endfunction

  task automatic send_item(bit mode, logic [31:0] ins, logic [63:0] ld);
    int unsigned pick, gap;
    pick = $urandom_range(0, 99);
    gap = no_gaps || pick < 60 ? 0 : (pick < 93 ? $urandom_range(1, 3) : $urandom_range(8, 40));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {ld, ins};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(execute_item(mode, ins, ld));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_start_address(logic [63:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (no_gaps || pick < 70) m_axis_tready <= 1'b1;
    else begin
      stall_left <= pick < 95 ? $urandom_range(0, 3) : $urandom_range(8, 40);
      m_axis_tready <= 1'b0;
    end
  end

  task automatic compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", m_axis_tdata);
      end else begin
        e = expected_q.pop_front();
        compare("reg_write", e.wb, m_axis_tdata[0]);
        compare("reg_index", e.rd, m_axis_tdata[5:1]);
        compare("reg_value", e.val, m_axis_tdata[69:6]);
        compare("next_pc", e.npc, m_axis_tdata[133:70]);
        compare("mem_request", e.mreq, m_axis_tdata[135:134]);
        compare("mem_address", e.maddr, m_axis_tdata[199:136]);
        compare("mem_size", e.msize, m_axis_tdata[201:200]);
        compare("store_data", e.sdata, m_axis_tdata[265:202]);
        compare("status", e.st, m_axis_tdata[267:266]);
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int rreg();
    return $urandom_range(0, 31);
  endfunction

  task automatic test_register_values;
    send_item(1'b0, {20'h80000, 5'd1, OP_LUI}, rnd64());
    send_item(1'b0, enc_i(12'hfff, 1, F3_ADD, 1, OP_IMM), rnd64());
    send_item(1'b0, enc_i(12'h7ff, 0, F3_ADD, 2, OP_IMM), rnd64());
    send_item(1'b0, enc_i(12'h800, 0, F3_ADD, 3, OP_IMM), rnd64());
    send_item(1'b0, {20'hfffff, 5'd4, OP_AUIPC}, rnd64());
    send_item(1'b0, enc_i(12'h001, 0, F3_ADD, 0, OP_IMM), rnd64());
  endtask

  task automatic test_alu_ops;
    for (int f = 0; f < 8; f++) begin
      send_item(1'b0, enc_r(F7_BASE, 3, 1, f[2:0], 5 + f, OP_REG), rnd64());
      send_item(1'b0, enc_r(F7_BASE, 2, 1, f[2:0], 6, OP_REG32), rnd64());
    end
    send_item(1'b0, enc_r(F7_ALT, 3, 1, F3_ADD, 7, OP_REG), rnd64());
    send_item(1'b0, enc_r(F7_ALT, 2, 1, F3_SR, 8, OP_REG), rnd64());
    send_item(1'b0, enc_i({F6_ALT, 6'd63}, 1, F3_SR, 9, OP_IMM), rnd64());
    send_item(1'b0, enc_i({F7_ALT, 5'd31}, 3, F3_SR, 10, OP_IMM32), rnd64());
    send_item(1'b0, enc_i(12'h03f, 3, F3_SLL, 11, OP_IMM), rnd64());
    send_item(1'b0, enc_r(F7_ALT, 3, 1, F3_SR, 12, OP_REG32), rnd64());
  endtask

  task automatic test_control_flow;
    for (int f = 0; f < 8; f++)
      send_item(1'b0, enc_b(13'h1ffc, 2, 3, f[2:0]), rnd64());
    send_item(1'b0, enc_j(21'h0ffffe, 1), rnd64());
    send_item(1'b0, enc_j(21'h100000, 0), rnd64());
    send_item(1'b0, enc_i(12'h7ff, 1, F3_ADD, 13, OP_JALR), rnd64());
  endtask

  task automatic test_memory;
    for (int f = 0; f < 8; f++) begin
      send_item(1'b0, enc_i(12'h800, 1, f[2:0], 14, OP_LOAD), rnd64());
      send_item(1'b1, $urandom(), 64'h8080808080808080);
      send_item(1'b0, enc_s(12'h7ff, 3, 1, f[2:0]), rnd64());
    end
    send_item(1'b0, enc_i(12'h000, 2, F3_ADD, 0, OP_LOAD), rnd64());
    send_item(1'b1, $urandom(), '1);
    send_item(1'b0, enc_i(12'h004, 2, F3_ADD, 15, OP_LOAD), rnd64());
    send_item(1'b0, enc_i(12'h001, 0, F3_ADD, 16, OP_IMM), rnd64());
    send_item(1'b1, $urandom(), '1);
  endtask

  task automatic test_exceptions;
    send_item(1'b0, 32'h00000073, rnd64());
    send_item(1'b0, 32'h0ff0000f, rnd64());
    send_item(1'b0, 32'hffffffff, rnd64());
    send_item(1'b0, 32'h00000000, rnd64());
    send_item(1'b0, enc_r(7'h01, 2, 1, F3_ADD, 5, OP_REG), rnd64());
    send_item(1'b0, enc_i({6'h01, 6'd0}, 1, F3_SLL, 5, OP_IMM), rnd64());
    send_item(1'b0, enc_i(12'h000, 1, F3_SLL, 5, OP_JALR), rnd64());
    send_item(1'b0, enc_r(F7_ALT, 2, 1, F3_SLL, 5, OP_REG32), rnd64());
  endtask

  function automatic logic [31:0] random_instruction();
    int unsigned k;
    logic [2:0] f3;
    k = $urandom_range(0, 99);
    f3 = 3'($urandom_range(0, 7));
    if (k < 10) return {20'($urandom_range(0, 1048575)), 5'(rreg()), OP_LUI};
    if (k < 20) return enc_i(12'($urandom()), rreg(), f3, rreg(), OP_IMM);
    if (k < 32) return enc_r($urandom_range(0, 9) < 7 ? F7_BASE : F7_ALT,
                             rreg(), rreg(), f3, rreg(), OP_REG);
    if (k < 38) return enc_r($urandom_range(0, 1) ? F7_BASE : F7_ALT,
                             rreg(), rreg(), f3, rreg(), OP_REG32);
    if (k < 44) return enc_i({$urandom_range(0, 1) ? F7_BASE : F7_ALT, 5'($urandom())},
                             rreg(), f3, rreg(), OP_IMM32);
    if (k < 52) return enc_b(13'($urandom()), rreg(), rreg(), f3);
    if (k < 56) return enc_j(21'($urandom()), rreg());
    if (k < 59) return enc_i(12'($urandom()), rreg(), F3_ADD, rreg(), OP_JALR);
    if (k < 62) return {20'($urandom_range(0, 1048575)), 5'(rreg()), OP_AUIPC};
    if (k < 76) return enc_i(12'($urandom()), rreg(), f3, rreg(), OP_LOAD);
    if (k < 86) return enc_s(12'($urandom()), rreg(), rreg(), f3);
    if (k < 89) return {25'($urandom_range(0, 33554431)),
                        $urandom_range(0, 1) ? OP_SYSTEM : OP_FENCE};
    return $urandom();
  endfunction

  task automatic test_random;
    logic [31:0] ins;
    for (int n = 0; n < 1550; n++) begin
      if (n % 450 == 449) write_start_address(n == 449 ? 64'd0 : rnd64());
      if (n % 200 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      ins = random_instruction();
      send_item(1'b0, ins, rnd64());
      if (ins[6:0] == OP_LOAD && ins[14:12] != F3_LBAD && $urandom_range(0, 9) < 8)
        send_item(1'b1, $urandom(), rnd64());
      else if ($urandom_range(0, 49) == 0)
        send_item(1'b1, $urandom(), rnd64());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    pc_model = '0;
    ld_model = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);
    write_start_address('1);
    test_register_values();
    test_alu_ops();
    test_control_flow();
    test_memory();
    test_exceptions();
    write_start_address(64'h0000_0000_8000_0000);
    test_random();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
sv/rvx_pkg.sv
sv/rvx_ram.sv
sv/rvx_exec.sv
sv/rv64i_integer_execute_unit_top.sv
sv/rvx_checker.sv
dv/testbench.sv
